>>> sv/dgr_pkg.sv
`timescale 1ns / 1ps

package dgr_pkg;

    // Item mode codes
    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_QUERY = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam int unsigned FIELD_W     = 4;
    localparam int unsigned COUNT_W     = 5;
    localparam logic [4:0]  COUNT_RESET = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WALK,
        ST_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic add_edge;
        logic clear_all;
        logic walk_start;
        logic walk_step;
        logic push;
    } t_dgr_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] mode;
        logic       range_err;
        logic       walk_done;
        logic       out_free;
    } t_dgr_stat;

endpackage

>>> sv/dgr_ctrl.sv
`timescale 1ns / 1ps

module dgr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dgr_pkg::t_dgr_stat  i_stat,
    output dgr_pkg::t_dgr_cmd   o_cmd
);

    dgr_pkg::t_state r_state;
    dgr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dgr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            dgr_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = dgr_pkg::ST_DECODE;
                end
            end
            dgr_pkg::ST_DECODE: begin
                n_state = dgr_pkg::ST_DONE;
                if (i_stat.mode == dgr_pkg::MODE_CLEAR) begin
                    o_cmd.clear_all = 1'b1;
                end else if (i_stat.mode == dgr_pkg::MODE_ADD && !i_stat.range_err) begin
                    o_cmd.add_edge = 1'b1;
                end else if (i_stat.mode == dgr_pkg::MODE_QUERY && !i_stat.range_err) begin
                    o_cmd.walk_start = 1'b1;
                    n_state          = dgr_pkg::ST_WALK;
                end
            end
            dgr_pkg::ST_WALK: begin
                if (i_stat.walk_done) begin
                    n_state = dgr_pkg::ST_DONE;
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            dgr_pkg::ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = dgr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dgr_pkg::ST_IDLE;
            end
        endcase
    end

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |-> i_stat.out_free)
        else $error("result pushed into a full output register");

    a_cmd_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command at once");

    a_step_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.walk_start |=> !o_cmd.push && r_state == dgr_pkg::ST_WALK)
        else $error("walk did not begin after start");

endmodule

>>> sv/dgr_datapath.sv
`timescale 1ns / 1ps

module dgr_datapath #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [1:0]                          i_mode,
    input  logic [dgr_pkg::FIELD_W-1:0]         i_from_vertex,
    input  logic [dgr_pkg::FIELD_W-1:0]         i_to_vertex,
    input  logic                                i_cfg_we,
    input  logic [dgr_pkg::COUNT_W-1:0]         i_cfg_data,
    input  logic                                i_out_ready,
    input  dgr_pkg::t_dgr_cmd                   i_cmd,
    output dgr_pkg::t_dgr_stat                  o_stat,
    output logic                                o_out_valid,
    output logic                                o_reachable,
    output logic                                o_status
);

    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    logic [dgr_pkg::COUNT_W-1:0]   r_vertex_count;
    logic [1:0]                    r_mode;
    logic [dgr_pkg::FIELD_W-1:0]   r_from;
    logic [dgr_pkg::FIELD_W-1:0]   r_to;
    logic [MAX_VERTICES-1:0]       r_adj [MAX_VERTICES];
    logic [MAX_VERTICES-1:0]       r_visited;
    logic [MAX_VERTICES-1:0]       r_pending;
    logic                          r_out_valid;
    logic                          r_reachable;
    logic                          r_status;

    logic [MAX_VERTICES-1:0]       w_mask;
    logic [VW-1:0]                 w_src_idx;
    logic [VW-1:0]                 w_dst_idx;
    logic [VW-1:0]                 w_sel_idx;
    logic [MAX_VERTICES-1:0]       w_sel_bit;
    logic [MAX_VERTICES-1:0]       w_src_bit;
    logic [MAX_VERTICES-1:0]       w_new;
    logic                          w_range_err;
    logic                          w_is_vertex_mode;
    logic                          w_hit;
    logic                          w_out_free;

    // Live vertex mask: bit i set while i is below the configured count
    for (genvar gi = 0; gi < MAX_VERTICES; gi++) begin : g_mask
        assign w_mask[gi] = (int'(r_vertex_count) > gi);
    end

    assign w_src_idx = VW'(r_from);
    assign w_dst_idx = VW'(r_to);
    assign w_src_bit = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << w_src_idx;

    assign w_range_err = (r_from >= 4'(r_vertex_count) && r_vertex_count < 5'd16)
                       || (r_to >= 4'(r_vertex_count) && r_vertex_count < 5'd16)
                       || (int'(r_from) >= MAX_VERTICES)
                       || (int'(r_to) >= MAX_VERTICES);

    // Lowest pending vertex is the next row to expand
    always_comb begin
        w_sel_idx = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
            if (r_pending[i]) begin
                w_sel_idx = VW'(i);
            end
        end
    end

    assign w_sel_bit = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << w_sel_idx;
    assign w_new     = r_adj[w_sel_idx] & w_mask & ~r_visited;
    assign w_hit     = r_visited[w_dst_idx];

    assign w_is_vertex_mode = (r_mode == dgr_pkg::MODE_ADD) || (r_mode == dgr_pkg::MODE_QUERY);
    assign w_out_free       = !r_out_valid || i_out_ready;

    assign o_stat.mode      = r_mode;
    assign o_stat.range_err = w_range_err;
    assign o_stat.walk_done = (r_pending == '0) || w_hit;
    assign o_stat.out_free  = w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= dgr_pkg::COUNT_RESET;
        end else if (i_cfg_we) begin
            r_vertex_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_from <= i_from_vertex;
            r_to   <= i_to_vertex;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_VERTICES; i++) begin
                r_adj[i] <= '0;
            end
            r_visited <= '0;
            r_pending <= '0;
        end else if (i_cmd.clear_all) begin
            for (int i = 0; i < MAX_VERTICES; i++) begin
                r_adj[i] <= '0;
            end
            r_visited <= '0;
            r_pending <= '0;
        end else if (i_cmd.add_edge) begin
            r_adj[w_src_idx][w_dst_idx] <= 1'b1;
        end else if (i_cmd.walk_start) begin
            r_visited <= w_src_bit;
            r_pending <= w_src_bit;
        end else if (i_cmd.walk_step) begin
            r_visited <= r_visited | w_new;
            r_pending <= (r_pending & ~w_sel_bit) | w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_reachable <= (r_mode == dgr_pkg::MODE_QUERY) && !w_range_err && w_hit;
            r_status    <= w_is_vertex_mode && w_range_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_reachable = r_reachable;
    assign o_status    = r_status;

    a_pending_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending & ~r_visited) == '0)
        else $error("pending vertex missing from visited set");

    a_walk_in_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk_step |-> (r_visited & ~w_mask) == '0)
        else $error("walk entered a vertex beyond the live count");

    a_clear_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_all |=> r_adj[0] == '0 && r_visited == '0)
        else $error("clear left edges behind");

endmodule

>>> sv/digraph_reachability.sv
`timescale 1ns / 1ps

// Channel    | Dir | Handshake                      | Payload
// s_axis     | in  | s_axis_tvalid / s_axis_tready  | tdata: mode, from_vertex, to_vertex
// m_axis     | out | m_axis_tvalid / m_axis_tready  | tdata: reachable, status
// cfg        | in  | i_cfg_valid / o_cfg_ready      | i_cfg_data: vertex_count
//
// Add, clear, rejected and mode-three items pass from accept through decode to the result
// push. A query walks between decode and push, expanding one adjacency row per cycle (at most
// vertex_count rows), and the walk stops early on a hit.
// Reset (i_rst_n low at a clock edge) clears all edges, drops any held result and returns
// vertex_count to 16. A stalled result is held in the output register; the block accepts
// the next item only after its result is pushed into that register.

module digraph_reachability #(
    parameter int MAX_VERTICES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [1:0] mode, [5:2] from_vertex, [9:6] to_vertex

    // Result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] reachable, [1] status

    // vertex_count register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data
);

    dgr_pkg::t_dgr_cmd  w_cmd;
    dgr_pkg::t_dgr_stat w_stat;
    logic               w_reachable;
    logic               w_status;

    // Register writes are always taken; they must only arrive while idle, which the block does not enforce
    assign o_cfg_ready = 1'b1;

    dgr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Adjacency matrix, walk sets and result register
    dgr_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mode        (s_axis_tdata[1:0]),
        .i_from_vertex (s_axis_tdata[5:2]),
        .i_to_vertex   (s_axis_tdata[9:6]),
        .i_cfg_we      (i_cfg_valid & o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (m_axis_tready),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_out_valid   (m_axis_tvalid),
        .o_reachable   (w_reachable),
        .o_status      (w_status)
    );

    // Pack result fields, lowest bit first, zero fill to a byte
    assign m_axis_tdata = {6'b000000, w_status, w_reachable};

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    // The fourth mode code has no meaning; the block must answer it as a no-op
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int STALL_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 24;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int NUM_PHASES      = 10;
    localparam int MAX_PRINTED     = 30;

    typedef struct packed {
        logic reachable;
        logic status;
    } t_reach_answer;

    // Tracks the graph and the vertex count, predicts the answer to every
    // accepted item and checks returned answers in order.
    class GraphReachTracker;
        logic [15:0]   adj_rows [16];
        logic [4:0]    vertex_count;
        t_reach_answer expected_answers [$];
        int            error_count;

        function new();
            clear_graph();
            vertex_count = dgr_pkg::COUNT_RESET;
            error_count  = 0;
        endfunction

        function void clear_graph();
            foreach (adj_rows[v])
                adj_rows[v] = '0;
        endfunction

        // Vertex numbers at or above this are rejected
        function int live_count();
            return (vertex_count > 5'd16) ? 16 : int'(vertex_count);
        endfunction

        // Grow the visited set from src one frontier at a time, never
        // stepping into vertices outside the live range.
        function logic reaches(logic [3:0] src, logic [3:0] dst, int cnt);
            logic [15:0] mask;
            logic [15:0] visited;
            logic [15:0] frontier;
            logic [15:0] next_set;
            mask = (cnt >= 16) ? 16'hFFFF : 16'((32'd1 << cnt) - 32'd1);
            visited = '0;
            visited[src] = 1'b1;
            frontier = visited;
            for (int s = 0; s < cnt && frontier != '0; s++) begin
                next_set = '0;
                for (int v = 0; v < 16; v++)
                    if (frontier[v])
                        next_set |= adj_rows[v];
                next_set &= mask & ~visited;
                visited |= next_set;
                frontier = next_set;
            end
            return visited[dst];
        endfunction

        function void note_item(logic [1:0] mode, logic [3:0] src, logic [3:0] dst);
            int            cnt;
            t_reach_answer ans;
            cnt = live_count();
            ans = '0;
            case (mode)
                dgr_pkg::MODE_CLEAR: begin
                    clear_graph();
                end
                dgr_pkg::MODE_ADD, dgr_pkg::MODE_QUERY: begin
                    if (src >= cnt || dst >= cnt)
                        ans.status = 1'b1;
                    else if (mode == dgr_pkg::MODE_ADD)
                        adj_rows[src][dst] = 1'b1;
                    else
                        ans.reachable = reaches(src, dst, cnt);
                end
                default: ;
            endcase
            expected_answers = {expected_answers, ans};
        endfunction

        task report(string msg);
            error_count++;
            if (error_count <= MAX_PRINTED)
                $display("ERROR @%0t: %s", $time, msg);
        endtask

        task check_result(logic [7:0] data);
            t_reach_answer want;
            if (expected_answers.size() == 0) begin
                report($sformatf("answer 0x%02h arrived with none pending", data));
            end else begin
                want = expected_answers.pop_front();
                if (data[0] !== want.reachable)
                    report($sformatf("reachable %b, expected %b", data[0], want.reachable));
                if (data[1] !== want.status)
                    report($sformatf("status %b, expected %b", data[1], want.status));
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [4:0]  i_cfg_data = '0;

    // Idle enables for each side; cleared together for a long full-rate run
    logic tx_idle_on = 1'b1;
    logic rx_idle_on = 1'b1;
    int   quiet_cycles = 0;

    GraphReachTracker graph;

    digraph_reachability #(
        .MAX_VERTICES(16)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Stall the result side in about a fifth of the cycles
    always @(posedge i_clk) begin
        if (rx_idle_on)
            m_axis_tready <= ($urandom_range(0, 99) >= 21);
        else
            m_axis_tready <= 1'b1;
    end

    // Observe handshakes with the values held before this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                graph.note_item(s_axis_tdata[1:0], s_axis_tdata[5:2], s_axis_tdata[9:6]);
            if (m_axis_tvalid && m_axis_tready)
                graph.check_result(m_axis_tdata);
            if (i_cfg_valid && o_cfg_ready)
                graph.vertex_count = i_cfg_data;
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TIMEOUT after %0d cycles without a handshake", quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one item, with a random gap ahead of it, and hold until taken
    task send_item(logic [1:0] mode, logic [3:0] src, logic [3:0] dst);
        int gap;
        gap = (tx_idle_on && $urandom_range(0, 99) < 21) ? $urandom_range(1, 6) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, dst, src, mode};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // Mostly in-range adds and queries so the graph fills up and walks go deep;
    // the rest are clears, the unused mode and vertex numbers from the whole field.
    task send_random_item();
        int         cnt;
        int         pick;
        logic [1:0] mode;
        logic [3:0] src;
        logic [3:0] dst;
        cnt  = graph.live_count();
        pick = $urandom_range(0, 99);
        src  = $urandom_range(0, 15);
        dst  = $urandom_range(0, 15);
        if (pick < 4) begin
            mode = dgr_pkg::MODE_CLEAR;
        end else if (pick < 7) begin
            mode = MODE_UNUSED;
        end else begin
            mode = (pick < 55) ? dgr_pkg::MODE_ADD : dgr_pkg::MODE_QUERY;
            if (pick % 8 != 0 && cnt > 0) begin
                src = $urandom_range(0, cnt - 1);
                dst = $urandom_range(0, cnt - 1);
            end
        end
        send_item(mode, src, dst);
    endtask

    // Hold the input side until every pending answer is back, then settle
    task wait_for_answers();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (graph.expected_answers.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task write_vertex_count(logic [4:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int count_plan [NUM_PHASES];
        graph = new();
        count_plan = '{16, 1, 2, 5, 16, 31, 3, 12, 0, 16};
        count_plan[7] = $urandom_range(1, 16);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: full vertex range
        write_vertex_count(5'd16);
        send_item(dgr_pkg::MODE_QUERY, 4'd0, 4'd0);      // a vertex reaches itself
        send_item(dgr_pkg::MODE_QUERY, 4'd0, 4'd15);
        send_item(dgr_pkg::MODE_ADD, 4'd0, 4'd15);
        send_item(dgr_pkg::MODE_ADD, 4'd15, 4'd0);
        send_item(dgr_pkg::MODE_QUERY, 4'd0, 4'd15);
        send_item(dgr_pkg::MODE_QUERY, 4'd15, 4'd0);
        send_item(dgr_pkg::MODE_ADD, 4'd1, 4'd2);
        send_item(dgr_pkg::MODE_ADD, 4'd2, 4'd3);
        send_item(dgr_pkg::MODE_ADD, 4'd3, 4'd4);
        send_item(dgr_pkg::MODE_ADD, 4'd1, 4'd2);        // repeated edge
        send_item(dgr_pkg::MODE_QUERY, 4'd1, 4'd4);
        send_item(dgr_pkg::MODE_QUERY, 4'd4, 4'd1);
        send_item(dgr_pkg::MODE_ADD, 4'd5, 4'd5);        // self loop
        send_item(dgr_pkg::MODE_QUERY, 4'd5, 4'd6);
        send_item(MODE_UNUSED, 4'd15, 4'd15);
        send_item(dgr_pkg::MODE_CLEAR, 4'd15, 4'd15);    // vertex fields ignored
        send_item(dgr_pkg::MODE_QUERY, 4'd0, 4'd15);
        send_item(dgr_pkg::MODE_ADD, 4'd0, 4'd9);
        send_item(dgr_pkg::MODE_ADD, 4'd9, 4'd1);
        wait_for_answers();

        // Shrink the count: the path through vertex 9 is now out of reach
        write_vertex_count(5'd2);
        send_item(dgr_pkg::MODE_QUERY, 4'd0, 4'd1);
        send_item(dgr_pkg::MODE_QUERY, 4'd0, 4'd2);
        send_item(dgr_pkg::MODE_ADD, 4'd2, 4'd0);
        send_item(dgr_pkg::MODE_ADD, 4'd1, 4'd1);
        wait_for_answers();

        // Zero count rejects everything
        write_vertex_count(5'd0);
        send_item(dgr_pkg::MODE_ADD, 4'd0, 4'd0);
        send_item(dgr_pkg::MODE_QUERY, 4'd0, 4'd0);
        wait_for_answers();

        // Oversized count caps at the full range; the stored path is live again
        write_vertex_count(5'd31);
        send_item(dgr_pkg::MODE_QUERY, 4'd0, 4'd1);
        wait_for_answers();

        // Random phases, one vertex count each; phase 4 runs without any idling
        for (int p = 0; p < NUM_PHASES; p++) begin
            tx_idle_on <= (p != 4);
            rx_idle_on <= (p != 4);
            write_vertex_count(5'(count_plan[p]));
            repeat (ITEMS_PER_PHASE) send_random_item();
            wait_for_answers();
        end

        if (graph.expected_answers.size() != 0)
            graph.report($sformatf("%0d answers never arrived", graph.expected_answers.size()));
        if (graph.error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
